// ----- hw/rtl/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv_pkg
// Types and constants shared by the rgb to hsv conversion pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int CH_W      = 8;
    localparam int HUE_W     = 9;
    localparam int SAT_NUM_W = 2 * CH_W;
    localparam int HUE_NUM_W = 14;
    localparam int SAT_Q_W   = 8;
    localparam int HUE_Q_W   = 6;
    localparam int DIV_STAGES = SAT_Q_W;

    localparam logic [HUE_W-1:0] HUE_OFF_RED   = 9'd0;
    localparam logic [HUE_W-1:0] HUE_OFF_GREEN = 9'd120;
    localparam logic [HUE_W-1:0] HUE_OFF_BLUE  = 9'd240;
    localparam logic [HUE_W:0]   HUE_WRAP      = 10'd360;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [CH_W-1:0]  sat_out;
        logic [CH_W-1:0]  val_out;
        logic [CH_W-1:0]  alpha_out;
    } t_hsv;

    // one word in flight through the divider stages
    typedef struct packed {
        logic [SAT_NUM_W-1:0] sat_rem;
        logic [SAT_Q_W-1:0]   sat_q;
        logic [HUE_NUM_W-1:0] hue_rem;
        logic [HUE_Q_W-1:0]   hue_q;
        logic [CH_W-1:0]      val;
        logic [CH_W-1:0]      delta;
        logic                 hue_neg;
        t_sector              sector;
        logic                 grey;
        logic                 black;
        logic [CH_W-1:0]      alpha;
    } t_div_lane;

endpackage

// ----- hw/rtl/hsv_front.sv -----
// ----------------------------------------------------------------------------
// hsv_front
// Input register, max/min and sector select, then the two dividends.
// ----------------------------------------------------------------------------
module hsv_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hsv_pkg::t_pixel    i_pixel,
    output logic               o_valid,
    output hsv_pkg::t_div_lane o_lane
);
    import hsv_pkg::*;

    logic        r_v0, r_v1, r_v2;
    t_pixel      r_pix;
    logic [CH_W-1:0] r_val, r_delta, r_mag, r_alpha;
    logic        r_neg;
    t_sector     r_sector;
    t_div_lane   r_lane;

    logic [CH_W-1:0] n_val, n_min, n_mag, op_a, op_b;
    logic        n_neg;
    t_sector     n_sector;
    t_div_lane   n_lane;

    // stage 1: largest, smallest, sector and hue difference
    always_comb begin
        n_min = r_pix.red_in;
        if (r_pix.green_in < n_min) n_min = r_pix.green_in;
        if (r_pix.blue_in < n_min)  n_min = r_pix.blue_in;

        priority if (r_pix.red_in >= r_pix.green_in && r_pix.red_in >= r_pix.blue_in) begin
            n_sector = SEC_RED;
            n_val    = r_pix.red_in;
            op_a     = r_pix.green_in;
            op_b     = r_pix.blue_in;
        end else if (r_pix.green_in >= r_pix.blue_in) begin
            n_sector = SEC_GREEN;
            n_val    = r_pix.green_in;
            op_a     = r_pix.blue_in;
            op_b     = r_pix.red_in;
        end else begin
            n_sector = SEC_BLUE;
            n_val    = r_pix.blue_in;
            op_a     = r_pix.red_in;
            op_b     = r_pix.green_in;
        end

        if (op_a >= op_b) begin
            n_neg = 1'b0;
            n_mag = op_a - op_b;
        end else begin
            n_neg = 1'b1;
            n_mag = op_b - op_a;
        end
    end

    // stage 2: 255*delta and 60*|diff| by shift and subtract
    always_comb begin
        n_lane         = '0;
        n_lane.sat_rem = {r_delta, 8'b0} - SAT_NUM_W'(r_delta);
        n_lane.hue_rem = HUE_NUM_W'({r_mag, 6'b0}) - HUE_NUM_W'({r_mag, 2'b0});
        n_lane.val     = r_val;
        n_lane.delta   = r_delta;
        n_lane.hue_neg = r_neg;
        n_lane.sector  = r_sector;
        n_lane.grey    = (r_delta == '0);
        n_lane.black   = (r_val == '0);
        n_lane.alpha   = r_alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix    <= i_pixel;
        r_val    <= n_val;
        r_delta  <= n_val - n_min;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_sector <= n_sector;
        r_alpha  <= r_pix.alpha_in;
        r_lane   <= n_lane;
    end

    assign o_valid = r_v2;
    assign o_lane  = r_lane;

endmodule

// ----- hw/rtl/hsv_div_pipe.sv -----
// ----------------------------------------------------------------------------
// hsv_div_pipe
// Pipelined restoring divider, one saturation quotient bit per stage; the hue
// quotient bits come only from the stages for its low HUE_Q_W bits.
// ----------------------------------------------------------------------------
module hsv_div_pipe (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hsv_pkg::t_div_lane i_lane,
    output logic               o_valid,
    output hsv_pkg::t_div_lane o_lane
);
    import hsv_pkg::*;

    logic      r_valid [0:DIV_STAGES-1];
    t_div_lane r_lane  [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BIT    = SAT_Q_W - 1 - k;
        localparam bit HUE_ON = (BIT < HUE_Q_W);
        localparam int HB     = HUE_ON ? BIT : 0;

        t_div_lane lane_in;
        t_div_lane n_lane;
        logic      valid_in;
        logic [SAT_NUM_W-1:0] sat_d;
        logic [HUE_NUM_W-1:0] hue_d;

        if (k == 0) begin : g_head
            assign lane_in  = i_lane;
            assign valid_in = i_valid;
        end else begin : g_body
            assign lane_in  = r_lane[k-1];
            assign valid_in = r_valid[k-1];
        end

        always_comb begin
            n_lane = lane_in;
            sat_d  = SAT_NUM_W'(lane_in.val) << BIT;
            hue_d  = HUE_NUM_W'(lane_in.delta) << HB;
            if (lane_in.sat_rem >= sat_d) begin
                n_lane.sat_rem    = lane_in.sat_rem - sat_d;
                n_lane.sat_q[BIT] = 1'b1;
            end
            if (HUE_ON && lane_in.hue_rem >= hue_d) begin
                n_lane.hue_rem   = lane_in.hue_rem - hue_d;
                n_lane.hue_q[HB] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_lane[k] <= n_lane;
        end
    end

    assign o_valid = r_valid[DIV_STAGES-1];
    assign o_lane  = r_lane[DIV_STAGES-1];

endmodule

// ----- hw/rtl/hsv_back.sv -----
// ----------------------------------------------------------------------------
// hsv_back
// Hue rounding and sector offset, special cases, and the result register.
// ----------------------------------------------------------------------------
module hsv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  hsv_pkg::t_div_lane i_lane,
    output logic               o_done,
    output hsv_pkg::t_hsv      o_hsv
);
    import hsv_pkg::*;

    logic        r_done;
    t_hsv        r_hsv;
    t_hsv        n_hsv;
    logic [HUE_Q_W:0]   mag;
    logic [HUE_W-1:0]   offset;
    logic [HUE_W:0]     hue_s;

    always_comb begin
        // floor of a negative quotient rounds away from zero
        mag = {1'b0, i_lane.hue_q} +
              (HUE_Q_W+1)'(i_lane.hue_neg && (i_lane.hue_rem != '0));

        unique case (i_lane.sector)
            SEC_RED:   offset = HUE_OFF_RED;
            SEC_GREEN: offset = HUE_OFF_GREEN;
            SEC_BLUE:  offset = HUE_OFF_BLUE;
            default:   offset = HUE_OFF_RED;
        endcase

        if (i_lane.hue_neg) begin
            hue_s = {1'b0, offset} - (HUE_W+1)'(mag);
        end else begin
            hue_s = {1'b0, offset} + (HUE_W+1)'(mag);
        end
        if (hue_s[HUE_W]) begin
            hue_s = hue_s + HUE_WRAP;
        end

        n_hsv.hue_deg   = i_lane.grey ? '0 : hue_s[HUE_W-1:0];
        n_hsv.sat_out   = i_lane.black ? '0 : i_lane.sat_q;
        n_hsv.val_out   = i_lane.val;
        n_hsv.alpha_out = i_lane.alpha;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hsv <= n_hsv;
    end

    assign o_done = r_done;
    assign o_hsv  = r_hsv;

endmodule

// ----- hw/rtl/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGBA pixel to HSV plus alpha, fully pipelined.
// ----------------------------------------------------------------------------
// One pixel is taken every clock: busy stays low, so start may be held high
// continuously. Each pixel yields one result word, shown with o_done for a
// single cycle, in order. The pipeline holds the input, min/max and dividend
// registers, the eight-stage divider (one saturation quotient bit per stage)
// and the result register. The receiver cannot stall the pipeline and must
// take each word in the cycle it appears.
module rgb_to_hsv_converter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  hsv_pkg::t_pixel i_pixel,
    output logic            busy,
    output logic            o_done,
    output hsv_pkg::t_hsv   o_hsv
);
    import hsv_pkg::*;

    logic      front_valid, div_valid;
    t_div_lane front_lane, div_lane;

    assign busy = 1'b0;

    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_pixel (i_pixel),
        .o_valid (front_valid),
        .o_lane  (front_lane)
    );

    hsv_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_lane  (front_lane),
        .o_valid (div_valid),
        .o_lane  (div_lane)
    );

    hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_lane  (div_lane),
        .o_done  (o_done),
        .o_hsv   (o_hsv)
    );

endmodule

// ----- tb/tb_rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// Feeds rgba pixels into the converter, predicts each hsv word in integer
// arithmetic and compares every o_done word against the oldest prediction.
// Directed corners come first, then random streams with varying input gaps.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
    import hsv_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int PHASE_ITEMS    = 567;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    t_pixel i_pixel;
    logic   busy;
    logic   o_done;
    t_hsv   o_hsv;

    t_hsv hsv_expected[$];
    int   mismatches      = 0;
    int   quiet_cycles    = 0;
    int   sender_idle_pct = 0;

    rgb_to_hsv_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pixel (i_pixel),
        .busy    (busy),
        .o_done  (o_done),
        .o_hsv   (o_hsv)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // floor division, rounding toward minus infinity for den > 0
    function automatic int div_floor(input int num, input int den);
        if (num >= 0) begin
            return num / den;
        end
        return -((-num + den - 1) / den);
    endfunction

    function automatic t_hsv predict_hsv(input t_pixel px);
        int   r, g, b, mx, mn, delta, hue, sat;
        t_hsv res;
        r  = int'(px.red_in);
        g  = int'(px.green_in);
        b  = int'(px.blue_in);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        // red wins ties over green, green over blue
        if (delta == 0) begin
            hue = 0;
        end else if (mx == r) begin
            hue = div_floor(60 * (g - b), delta) + int'(HUE_OFF_RED);
        end else if (mx == g) begin
            hue = div_floor(60 * (b - r), delta) + int'(HUE_OFF_GREEN);
        end else begin
            hue = div_floor(60 * (r - g), delta) + int'(HUE_OFF_BLUE);
        end
        if (hue < 0) hue += int'(HUE_WRAP);
        sat = (mx == 0) ? 0 : (255 * delta) / mx;
        res.hue_deg   = hue[HUE_W-1:0];
        res.sat_out   = sat[CH_W-1:0];
        res.val_out   = mx[CH_W-1:0];
        res.alpha_out = px.alpha_in;
        return res;
    endfunction

    always @(posedge i_clk) begin : hsv_scoreboard
        t_hsv want;
        if (i_rst_n && start && !busy) begin
            hsv_expected.push_back(predict_hsv(i_pixel));
        end
        if (i_rst_n && o_done) begin
            if (hsv_expected.size() == 0) begin
                $error("result word with no pixel pending: %h", o_hsv);
                mismatches++;
            end else begin
                want = hsv_expected.pop_front();
                if (o_hsv.hue_deg !== want.hue_deg) begin
                    $error("hue_deg expected %0d actual %0d", want.hue_deg, o_hsv.hue_deg);
                    mismatches++;
                end
                if (o_hsv.sat_out !== want.sat_out) begin
                    $error("sat_out expected %0d actual %0d", want.sat_out, o_hsv.sat_out);
                    mismatches++;
                end
                if (o_hsv.val_out !== want.val_out) begin
                    $error("val_out expected %0d actual %0d", want.val_out, o_hsv.val_out);
                    mismatches++;
                end
                if (o_hsv.alpha_out !== want.alpha_out) begin
                    $error("alpha_out expected %0d actual %0d",
                           want.alpha_out, o_hsv.alpha_out);
                    mismatches++;
                end
            end
        end
    end

    // ends the run if neither a pixel nor a result moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(99) < sender_idle_pct) begin
            start   <= 1'b0;
            i_pixel <= t_pixel'($urandom);
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_pixel <= px;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic send_rgba(input int r, input int g, input int b, input int a);
        t_pixel px;
        px.red_in   = r[CH_W-1:0];
        px.green_in = g[CH_W-1:0];
        px.blue_in  = b[CH_W-1:0];
        px.alpha_in = a[CH_W-1:0];
        send_pixel(px);
    endtask

    function automatic int clamp_channel(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic t_pixel random_pixel();
        int     kind, r;
        t_pixel px;
        kind = int'($urandom_range(99));
        px   = t_pixel'($urandom);
        r    = int'(px.red_in);
        if (kind < 10) begin
            px.green_in = px.red_in;
            px.blue_in  = px.red_in;
        end else if (kind < 25) begin
            // two channels tied, the third anywhere
            case ($urandom_range(2))
                0: px.green_in = px.red_in;
                1: px.blue_in  = px.green_in;
                default: px.blue_in = px.red_in;
            endcase
        end else if (kind < 40) begin
            // near grey, small delta stresses the hue division
            px.green_in = CH_W'(clamp_channel(r + int'($urandom_range(6)) - 3));
            px.blue_in  = CH_W'(clamp_channel(r + int'($urandom_range(6)) - 3));
        end
        return px;
    endfunction

    task automatic test_channel_extremes();
        send_rgba(0, 0, 0, 0);
        send_rgba(255, 255, 255, 255);
        send_rgba(128, 128, 128, 170);
        send_rgba(255, 0, 0, 85);
        send_rgba(0, 255, 0, 255);
        send_rgba(0, 0, 255, 0);
        send_rgba(1, 0, 0, 1);
        send_rgba(0, 0, 1, 254);
        send_rgba(170, 85, 85, 170);
        send_rgba(85, 170, 170, 85);
    endtask

    task automatic test_max_ties();
        send_rgba(255, 255, 0, 17);
        send_rgba(0, 255, 255, 34);
        send_rgba(255, 0, 255, 51);
        send_rgba(200, 200, 100, 68);
        send_rgba(40, 90, 90, 102);
        send_rgba(77, 3, 77, 136);
    endtask

    task automatic test_hue_wrap();
        send_rgba(255, 0, 1, 200);
        send_rgba(200, 10, 11, 201);
        send_rgba(255, 254, 255, 202);
        send_rgba(10, 200, 5, 203);
        send_rgba(0, 1, 255, 204);
        send_rgba(2, 1, 0, 205);
    endtask

    task automatic test_random_stream(input int idle_pct, input int count);
        sender_idle_pct = idle_pct;
        repeat (count) send_pixel(random_pixel());
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_pixel = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_channel_extremes();
        test_max_ties();
        test_hue_wrap();
        test_random_stream(16, PHASE_ITEMS);
        test_random_stream(83, PHASE_ITEMS);
        test_random_stream(0, PHASE_ITEMS);

        start <= 1'b0;
        while (hsv_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
